@@ hw/rtl/byte_memory_with_wildcard_search_core_assert.svh @@
// assertion macros shared by the checker
`ifndef BYTE_MEMORY_WITH_WILDCARD_SEARCH_CORE_ASSERT_SVH
`define BYTE_MEMORY_WITH_WILDCARD_SEARCH_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, idle during reset
`define BMWS_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmws assertion failed");

// next-cycle implication, sampled on clk, idle during reset
`define BMWS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmws assertion failed");

`endif

@@ hw/rtl/bmws_pkg.sv @@
package bmws_pkg;

    localparam logic [2:0] MODE_WR_BYTE = 3'd0;
    localparam logic [2:0] MODE_WR_WORD = 3'd1;
    localparam logic [2:0] MODE_RD_BYTE = 3'd2;
    localparam logic [2:0] MODE_RD_WORD = 3'd3;
    localparam logic [2:0] MODE_SEARCH  = 3'd4;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_OOB   = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    localparam logic [1:0] REG_PAT_LO = 2'd0;
    localparam logic [1:0] REG_PAT_HI = 2'd1;
    localparam logic [1:0] REG_MASK   = 2'd2;
    localparam logic [1:0] REG_LEN    = 2'd3;

    // reset fill, byte i holds entry i mod 4
    localparam logic [7:0] FILL_0 = 8'hde;
    localparam logic [7:0] FILL_1 = 8'had;
    localparam logic [7:0] FILL_2 = 8'hbe;
    localparam logic [7:0] FILL_3 = 8'hef;

    typedef struct packed {
        logic [63:0] pat_lo;
        logic [63:0] pat_hi;
        logic [15:0] mask;
        logic [4:0]  len;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SEARCH
    } state_t;

endpackage

@@ hw/rtl/bmws_regs.sv @@
module bmws_regs (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [63:0]      pwdata,
    output logic [63:0]      prdata,
    output logic             pready,
    output bmws_pkg::cfg_t   cfg
);
    import bmws_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[4:3])
                REG_PAT_LO: cfg_next.pat_lo = pwdata;
                REG_PAT_HI: cfg_next.pat_hi = pwdata;
                REG_MASK:   cfg_next.mask   = pwdata[15:0];
                REG_LEN:    cfg_next.len    = pwdata[4:0];
                default:    cfg_next        = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:3])
            REG_PAT_LO: prdata = cfg_reg.pat_lo;
            REG_PAT_HI: prdata = cfg_reg.pat_hi;
            REG_MASK:   prdata = {48'd0, cfg_reg.mask};
            REG_LEN:    prdata = {59'd0, cfg_reg.len};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ hw/rtl/bmws_bank.sv @@
module bmws_bank #(
    parameter int          DEPTH     = 32769,
    parameter logic [7:0]  FILL_ROW0 = 8'hde,
    parameter logic [7:0]  FILL_ROW1 = 8'hbe,
    localparam int         IW        = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          we,
    input  logic [IW-1:0] widx,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [IW-1:0] ridx,
    output logic [7:0]    rdata,
    output logic          busy
);

    logic [7:0]    mem [DEPTH];
    logic [7:0]    rdata_reg;
    logic [IW-1:0] clr_idx_reg;
    logic [IW-1:0] clr_idx_next;
    logic          clr_busy_reg;
    logic          clr_busy_next;
    logic [7:0]    fill;

    assign rdata = rdata_reg;
    assign busy  = clr_busy_reg;
    assign fill  = clr_idx_reg[0] ? FILL_ROW1 : FILL_ROW0;

    // clearing pass after reset, writing the fill into every row in turn
    always_comb
    begin
        clr_idx_next  = clr_idx_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            if (clr_idx_reg == IW'(DEPTH - 1))
            begin
                clr_busy_next = 1'b0;
            end
            else
            begin
                clr_idx_next = clr_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_idx_reg  <= clr_idx_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_idx_reg] <= fill;
        end
        else if (we)
        begin
            mem[widx] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[ridx];
        end
    end

endmodule

@@ hw/rtl/bmws_ctrl.sv @@
module bmws_ctrl #(
    parameter int  MEM_SIZE    = 65536,
    parameter int  PATTERN_MAX = 16,
    localparam int HALF        = MEM_SIZE / 2 + 1,
    localparam int IW          = $clog2(HALF)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  bmws_pkg::cfg_t  cfg,
    input  logic            clr_busy,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [2:0]      mode,
    input  logic [15:0]     address,
    input  logic [16:0]     end_offset,
    input  logic            whole_memory,
    input  logic [15:0]     write_data,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [15:0]     read_data,
    output logic            found,
    output logic [15:0]     found_offset,
    output logic [1:0]      status,
    output logic            ev_we,
    output logic [IW-1:0]   ev_widx,
    output logic [7:0]      ev_wdata,
    output logic            ev_re,
    output logic [IW-1:0]   ev_ridx,
    input  logic [7:0]      ev_rdata,
    output logic            od_we,
    output logic [IW-1:0]   od_widx,
    output logic [7:0]      od_wdata,
    output logic            od_re,
    output logic [IW-1:0]   od_ridx,
    input  logic [7:0]      od_rdata
);
    import bmws_pkg::*;

    localparam int CW = ($clog2(MEM_SIZE + 2) > 17) ? $clog2(MEM_SIZE + 2) : 17;

    state_t          state_reg;
    state_t          state_next;

    logic            acc;
    logic            out_free;
    logic [CW-1:0]   a_ext;
    logic [CW-1:0]   a_p1;
    logic            byte_oob;
    logic            word_oob;
    logic [4:0]      len_sat;
    logic [CW-1:0]   s_start;
    logic [CW-1:0]   s_end;
    logic            s_empty;
    logic            s_short;
    logic            go_read;
    logic            go_search;
    logic            wr_byte;
    logic            wr_word;
    logic [CW-1:0]   ra;
    logic [CW-1:0]   ra_p1;
    logic            issue;

    logic [CW-1:0]   q_reg;
    logic [CW-1:0]   last_reg;
    logic [CW-1:0]   first_reg;
    logic            s1_valid_reg;
    logic [CW-1:0]   s1_q_reg;
    logic            s2_valid_reg;
    logic [CW-1:0]   s2_q_reg;
    logic [7:0]      win_reg [PATTERN_MAX];
    logic [7:0]      s1_byte;
    logic [127:0]    pat_all;
    logic [7:0]      apat [PATTERN_MAX];
    logic            awild [PATTERN_MAX];
    logic            hit;
    logic            s_match;
    logic            s_done;
    logic [CW-1:0]   match_pos;

    logic            rd_odd_reg;
    logic            rd_word_reg;
    logic [7:0]      rd_lo;
    logic [7:0]      rd_hi;

    logic            ld;
    logic [15:0]     ld_rdata;
    logic            ld_found;
    logic [15:0]     ld_off;
    logic [1:0]      ld_status;

    logic            out_valid_reg;
    logic            out_valid_next;
    logic [15:0]     read_data_reg;
    logic            found_reg;
    logic [15:0]     found_offset_reg;
    logic [1:0]      status_reg;

    // transaction decode
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == ST_IDLE) && !clr_busy && out_free);
    assign acc      = in_valid && !in_stall;

    assign a_ext    = CW'(address);
    assign a_p1     = a_ext + 1'b1;
    assign byte_oob = a_ext >= CW'(MEM_SIZE);
    assign word_oob = a_p1 >= CW'(MEM_SIZE);
    assign len_sat  = (cfg.len > 5'(PATTERN_MAX)) ? 5'(PATTERN_MAX) : cfg.len;

    always_comb
    begin
        if (whole_memory)
        begin
            s_start = '0;
            s_end   = CW'(MEM_SIZE - 1);
        end
        else
        begin
            s_start = a_ext;
            s_end   = (CW'(end_offset) < CW'(MEM_SIZE)) ? CW'(end_offset) : CW'(MEM_SIZE);
        end
    end

    assign s_empty   = s_start >= s_end;
    assign s_short   = (s_start + CW'(len_sat)) >= s_end;
    assign go_read   = ((mode == MODE_RD_BYTE) && !byte_oob) ||
                       ((mode == MODE_RD_WORD) && !word_oob);
    assign go_search = (mode == MODE_SEARCH) && !s_empty && (len_sat != 5'd0) && !s_short;
    assign wr_byte   = acc && (mode == MODE_WR_BYTE) && !byte_oob;
    assign wr_word   = acc && (mode == MODE_WR_WORD) && !word_oob;

    // even bank holds byte 2k at row k, odd bank byte 2k+1
    assign ev_widx  = a_p1[IW:1];
    assign od_widx  = a_ext[IW:1];
    assign ev_we    = wr_word || (wr_byte && !address[0]);
    assign od_we    = wr_word || (wr_byte && address[0]);
    assign ev_wdata = (wr_word && address[0]) ? write_data[15:8] : write_data[7:0];
    assign od_wdata = (wr_word && !address[0]) ? write_data[15:8] : write_data[7:0];

    assign ra      = (state_reg == ST_IDLE) ? a_ext : q_reg;
    assign ra_p1   = ra + 1'b1;
    assign ev_ridx = ra_p1[IW:1];
    assign od_ridx = ra[IW:1];
    assign issue   = (state_reg == ST_SEARCH) && (q_reg <= last_reg) && !s_done;
    assign ev_re   = (acc && go_read) || issue;
    assign od_re   = ev_re;

    assign rd_lo = rd_odd_reg ? od_rdata : ev_rdata;
    assign rd_hi = rd_odd_reg ? ev_rdata : od_rdata;

    // pattern aligned to the window, newest byte in entry 0
    assign pat_all = {cfg.pat_hi, cfg.pat_lo};

    always_comb
    begin
        logic [4:0] pidx;
        pidx = '0;
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            pidx = len_sat - 5'(k) - 5'd1;
            if (5'(k) < len_sat)
            begin
                apat[k]  = pat_all[{pidx[3:0], 3'b000} +: 8];
                awild[k] = cfg.mask[pidx[3:0]];
            end
            else
            begin
                apat[k]  = '0;
                awild[k] = 1'b1;
            end
        end
    end

    always_comb
    begin
        hit = 1'b1;
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            hit = hit & (awild[k] | (win_reg[k] == apat[k]));
        end
    end

    assign s1_byte   = s1_q_reg[0] ? od_rdata : ev_rdata;
    assign s_match   = s2_valid_reg && (s2_q_reg >= first_reg) && hit;
    assign s_done    = (state_reg == ST_SEARCH) &&
                       (s_match || (s2_valid_reg && (s2_q_reg == last_reg)));
    assign match_pos = s2_q_reg - CW'(len_sat) + 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc && go_read)
                begin
                    state_next = ST_READ;
                end
                else if (acc && go_search)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_READ:   state_next = ST_IDLE;
            ST_SEARCH:
            begin
                if (s_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // result load
    always_comb
    begin
        ld        = 1'b0;
        ld_rdata  = '0;
        ld_found  = 1'b0;
        ld_off    = '0;
        ld_status = STATUS_OK;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc && !go_read && !go_search)
                begin
                    ld = 1'b1;
                    case (mode)
                        MODE_WR_BYTE, MODE_RD_BYTE:
                        begin
                            if (byte_oob)
                            begin
                                ld_status = STATUS_OOB;
                            end
                        end
                        MODE_WR_WORD, MODE_RD_WORD:
                        begin
                            if (word_oob)
                            begin
                                ld_status = STATUS_OOB;
                            end
                        end
                        MODE_SEARCH:
                        begin
                            if (s_empty)
                            begin
                                ld_status = STATUS_RANGE;
                            end
                            else if (len_sat == 5'd0)
                            begin
                                ld_found = 1'b1;
                                ld_off   = s_start[15:0];
                            end
                        end
                        default: ld_status = STATUS_OK;
                    endcase
                end
            end
            ST_READ:
            begin
                ld       = 1'b1;
                ld_rdata = rd_word_reg ? {rd_hi, rd_lo} : {8'd0, rd_lo};
            end
            ST_SEARCH:
            begin
                if (s_done)
                begin
                    ld       = 1'b1;
                    ld_found = s_match;
                    ld_off   = s_match ? match_pos[15:0] : 16'd0;
                end
            end
            default: ld = 1'b0;
        endcase
    end

    assign out_valid_next = ld || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            s1_valid_reg  <= issue;
            s2_valid_reg  <= s1_valid_reg && (state_reg == ST_SEARCH) && !s_done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            read_data_reg    <= ld_rdata;
            found_reg        <= ld_found;
            found_offset_reg <= ld_off;
            status_reg       <= ld_status;
        end
        if (acc && go_read)
        begin
            rd_odd_reg  <= address[0];
            rd_word_reg <= (mode == MODE_RD_WORD);
        end
        if (acc && go_search)
        begin
            q_reg     <= s_start;
            last_reg  <= s_end - CW'(2);
            first_reg <= s_start + CW'(len_sat) - 1'b1;
        end
        else if (issue)
        begin
            q_reg <= q_reg + 1'b1;
        end
        s1_q_reg <= q_reg;
        s2_q_reg <= s1_q_reg;
        if (s1_valid_reg)
        begin
            win_reg[0] <= s1_byte;
            for (int k = 1; k < PATTERN_MAX; k++)
            begin
                win_reg[k] <= win_reg[k-1];
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_data    = read_data_reg;
    assign found        = found_reg;
    assign found_offset = found_offset_reg;
    assign status       = status_reg;

endmodule

@@ hw/rtl/byte_memory_with_wildcard_search_core.sv @@
// byte memory with wildcard pattern search
// input channel: in_valid/in_stall carries mode, address, end_offset, whole_memory and
// write_data; every transaction gives exactly one result on out_valid/out_stall
// (read_data, found, found_offset, status)
// writes, out-of-bounds accesses, empty or too-short ranges, zero-length patterns and
// unused modes: result in the next cycle, one transaction per cycle while unstalled
// byte and word reads: the two byte banks (even and odd addresses) serve a word in one
// registered read, then the result is loaded; no new transaction is taken meanwhile
// search: one byte per cycle streamed through a window register, set by the bank read
// port; no new transaction is taken until the result is loaded
// the user must write the pattern registers (apb port) only while idle; not enforced
// reset: config registers clear to zero and a clearing pass writes the de ad be ef fill
// into MEM_SIZE/2 + 1 rows, one row of both banks per cycle, in_stall high meanwhile
// a stalled result is held in the output register; a new transaction is taken only
// when that register is empty or being taken in the same cycle
module byte_memory_with_wildcard_search_core #(
    parameter int MEM_SIZE    = 65536,
    parameter int PATTERN_MAX = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  mode,
    input  logic [15:0] address,
    input  logic [16:0] end_offset,
    input  logic        whole_memory,
    input  logic [15:0] write_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] read_data,
    output logic        found,
    output logic [15:0] found_offset,
    output logic [1:0]  status
);
    import bmws_pkg::*;

    localparam int HALF = MEM_SIZE / 2 + 1;
    localparam int IW   = $clog2(HALF);

    cfg_t          cfg;
    logic          ev_we;
    logic [IW-1:0] ev_widx;
    logic [7:0]    ev_wdata;
    logic          ev_re;
    logic [IW-1:0] ev_ridx;
    logic [7:0]    ev_rdata;
    logic          ev_busy;
    logic          od_we;
    logic [IW-1:0] od_widx;
    logic [7:0]    od_wdata;
    logic          od_re;
    logic [IW-1:0] od_ridx;
    logic [7:0]    od_rdata;
    logic          od_busy;

    bmws_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bmws_bank #(
        .DEPTH     (HALF),
        .FILL_ROW0 (FILL_0),
        .FILL_ROW1 (FILL_2)
    ) u_bank_even (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (ev_we),
        .widx  (ev_widx),
        .wdata (ev_wdata),
        .re    (ev_re),
        .ridx  (ev_ridx),
        .rdata (ev_rdata),
        .busy  (ev_busy)
    );

    bmws_bank #(
        .DEPTH     (HALF),
        .FILL_ROW0 (FILL_1),
        .FILL_ROW1 (FILL_3)
    ) u_bank_odd (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (od_we),
        .widx  (od_widx),
        .wdata (od_wdata),
        .re    (od_re),
        .ridx  (od_ridx),
        .rdata (od_rdata),
        .busy  (od_busy)
    );

    bmws_ctrl #(
        .MEM_SIZE    (MEM_SIZE),
        .PATTERN_MAX (PATTERN_MAX)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .clr_busy     (ev_busy || od_busy),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .address      (address),
        .end_offset   (end_offset),
        .whole_memory (whole_memory),
        .write_data   (write_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .read_data    (read_data),
        .found        (found),
        .found_offset (found_offset),
        .status       (status),
        .ev_we        (ev_we),
        .ev_widx      (ev_widx),
        .ev_wdata     (ev_wdata),
        .ev_re        (ev_re),
        .ev_ridx      (ev_ridx),
        .ev_rdata     (ev_rdata),
        .od_we        (od_we),
        .od_widx      (od_widx),
        .od_wdata     (od_wdata),
        .od_re        (od_re),
        .od_ridx      (od_ridx),
        .od_rdata     (od_rdata)
    );

endmodule

@@ hw/rtl/bmws_checker.sv @@
`include "byte_memory_with_wildcard_search_core_assert.svh"

module bmws_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] read_data,
    input logic        found,
    input logic [15:0] found_offset,
    input logic [1:0]  status
);
    import bmws_pkg::*;

    logic [32:0] out_rest;
    logic [34:0] out_word;

    assign out_rest = {read_data, found, found_offset};
    assign out_word = {out_rest, status};

    `BMWS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))

    `BMWS_ASSERT_IMPL(a_no_accept_full, in_valid && out_valid && out_stall, in_stall)

    `BMWS_ASSERT_IMPL(a_found_clean, out_valid && found, status == STATUS_OK && read_data == 16'd0)

    `BMWS_ASSERT_IMPL(a_error_clean, out_valid && status != STATUS_OK, out_rest == 33'd0)

    `BMWS_ASSERT_IMPL(a_miss_offset, out_valid && !found, found_offset == 16'd0)

endmodule

bind byte_memory_with_wildcard_search_core bmws_checker u_bmws_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .read_data    (read_data),
    .found        (found),
    .found_offset (found_offset),
    .status       (status)
);
